FILE: sv/lru_key_value_cache_assert.svh
// ----------------------------------------------------------------------------
// lru_key_value_cache_assert
// Assertion macros for the LRU key/value cache.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkvc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkvc assertion failed");

`endif

FILE: sv/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and sizing constants for the fully associative LRU key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 4;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SAVE = 1'b1;

  typedef struct packed {
    logic                     action;
    logic signed [KEY_W-1:0]  lookup_key;
    logic signed [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_data;
    logic                     evicted;
    logic signed [KEY_W-1:0]  evicted_key;
  } out_item_t;

endpackage

`default_nettype wire

FILE: sv/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel carrying one request (load or save of a key).
//   out_* : valid/ready channel carrying exactly one result per request.
//   cfg_* : valid/ready write of the 4-bit capacity limit; always ready.
//           Write it only while no request is in flight.
// Timing: a request lands in an input register on its transfer; when the
//   result register can take it, the parallel key compare, the rank update
//   and the store write are performed and the result register is loaded.
//   One request per cycle is sustained while out_ready stays high; the
//   compare-and-update over all slots is combinational.
// Stall: while the result register is full and out_ready is low, the input
//   register holds its request and in_ready drops once it is occupied.
// Reset: rst_n (synchronous, active low) empties the store, clears the valid
//   flags of both pipeline registers and sets the capacity limit to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire lkvc_pkg::in_item_t        in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output lkvc_pkg::out_item_t            out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [lkvc_pkg::CAP_W-1:0] cfg_data
);

  import lkvc_pkg::*;

  // pipeline registers
  in_item_t    ir_r;
  logic        ir_vld_r;
  out_item_t   out_data_r;
  out_item_t   out_data_nxt;
  logic        out_valid_r;

  // store state
  logic [ENTRIES-1:0]             valid_r, valid_nxt;
  logic [KEY_W-1:0]               key_r     [ENTRIES];
  logic [KEY_W-1:0]               key_nxt   [ENTRIES];
  logic [DATA_W-1:0]              value_r   [ENTRIES];
  logic [DATA_W-1:0]              value_nxt [ENTRIES];
  logic [IDX_W-1:0]               rank_r    [ENTRIES];
  logic [IDX_W-1:0]               rank_nxt  [ENTRIES];
  logic [CNT_W-1:0]               occ_r, occ_nxt;
  logic [CAP_W-1:0]               cap_r;

  logic advance;
  logic is_save;
  logic hit;
  logic evict;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] lru_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [IDX_W-1:0]   hit_rank;
  logic [DATA_W-1:0]  hit_value;
  logic [KEY_W-1:0]   lru_key;
  logic [IDX_W-1:0]   lru_rank;
  logic [IDX_W-1:0]   free_idx;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   occ_ext;
  logic [CMP_W-1:0]   eff_cap;

  assign advance   = ir_vld_r && (!out_valid_r || out_ready);
  assign in_ready  = !ir_vld_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign is_save   = (ir_r.action == ACT_SAVE);

  // capacity clamp: zero acts as one, anything above ENTRIES as ENTRIES
  assign cap_ext  = CMP_W'(cap_r);
  assign occ_ext  = CMP_W'(occ_r);
  assign eff_cap  = (cap_r == '0) ? CMP_W'(1) :
                    ((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);
  assign lru_rank = IDX_W'(occ_r - CNT_W'(1));

  always_comb begin
    hit_vec   = '0;
    lru_vec   = '0;
    hit_rank  = '0;
    hit_value = '0;
    lru_key   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == ir_r.lookup_key);
      // valid ranks are distinct, so the oldest entry is the one at occ-1
      lru_vec[i] = valid_r[i] && (rank_r[i] == lru_rank);
      // keys in valid slots are unique, so the match vector is one-hot
      if (hit_vec[i]) begin
        hit_rank  = hit_rank  | rank_r[i];
        hit_value = hit_value | value_r[i];
      end
      if (lru_vec[i]) begin
        lru_key = lru_key | key_r[i];
      end
    end
  end

  assign hit   = |hit_vec;
  assign evict = is_save && !hit && (occ_r != '0) && (occ_ext >= eff_cap);

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      free_vec[i] = !valid_r[i] || (evict && lru_vec[i]);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    rank_nxt  = rank_r;
    occ_nxt   = occ_r;
    if (advance) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit_vec[i]) begin
            rank_nxt[i] = '0;
            if (is_save) begin
              value_nxt[i] = ir_r.write_data;
            end
          end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
            rank_nxt[i] = rank_r[i] + IDX_W'(1);
          end
        end
      end else if (is_save) begin
        // every surviving entry ages by one; the new pair becomes most recent
        for (int i = 0; i < ENTRIES; i++) begin
          valid_nxt[i] = !free_vec[i];
          if (!free_vec[i]) begin
            rank_nxt[i] = rank_r[i] + IDX_W'(1);
          end
        end
        valid_nxt[free_idx] = 1'b1;
        key_nxt[free_idx]   = ir_r.lookup_key;
        value_nxt[free_idx] = ir_r.write_data;
        rank_nxt[free_idx]  = '0;
        occ_nxt = evict ? occ_r : occ_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_data_nxt.hit         = hit;
    out_data_nxt.read_data   = (hit && !is_save) ? hit_value : '0;
    out_data_nxt.evicted     = evict;
    out_data_nxt.evicted_key = evict ? lru_key : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      occ_r       <= '0;
      cap_r       <= CAP_W'(8);
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        ir_vld_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      rank_r  <= rank_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

`include "lru_key_value_cache_assert.svh"

  // fill count tracks the valid bits
  `LKVC_ASSERT_IMP(a_occ_matches_valid, clk, rst_n, 1'b1, $countones(valid_r) == occ_r)
  // an eviction leaves the fill count unchanged
  `LKVC_ASSERT_NXT(a_evict_keeps_occ, clk, rst_n, advance && evict, occ_r == $past(occ_r))
  // a hit never changes the set of valid slots
  `LKVC_ASSERT_NXT(a_hit_keeps_valid, clk, rst_n, advance && hit, valid_r == $past(valid_r))

endmodule

`default_nettype wire
